// ===== hdl/skit_pkg.sv =====
// shared types and constants for the sorted key index table
// used by sorted_key_index_table, skit_store and skit_checker; no dependencies
package skit_pkg;

   localparam int KEY_BYTES   = 5;
   localparam int KEY_W       = 8 * KEY_BYTES;
   localparam int OFF_W       = 31;
   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_DUPLICATE = 2'd3;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [KEY_W-1:0] key;
      logic [OFF_W-1:0] offset;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [OFF_W-1:0] found_offset;
      logic [CNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [OFF_W-1:0] offset;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      entry_type         wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_CMP,
      S_HITCMP,
      S_DECIDE,
      S_INS_RD,
      S_INS_WR,
      S_DEL_RD,
      S_DEL_WR,
      S_DONE
   } state_type;

endpackage

// ===== hdl/skit_store.sv =====
// entry memory of the index table: one write port, one registered read port
// depends on skit_pkg
module skit_store (
   input  logic                  clock,
   input  skit_pkg::mem_cmd_type cmd,
   output skit_pkg::entry_type   rd_data
);

   skit_pkg::entry_type mem [skit_pkg::TABLE_DEPTH];
   skit_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
      rd_data_ff <= mem[cmd.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sorted_key_index_table.sv =====
// sorted key index table: binary search and entry shifting sequencer
// depends on skit_pkg and skit_store
//
// Keeps up to TABLE_DEPTH entries of (key, offset), sorted by key. A request
// carries opcode (insert, lookup, delete), key and offset; each request gives
// exactly one response with status, found_offset and entry_count.
// Keys are normalized on entry: bytes after the first zero byte read as zero.
// req_ready is high only while the sequencer is idle; one request is worked
// on at a time. All entries live in a single-port-read memory, so every
// probe first issues the address, then compares the registered data.
// An insert or delete that succeeds also moves every entry after the slot
// by one to open or close the gap. The response sits in an output
// register; the next request is taken while it waits, and the sequencer
// holds a finished result until the output register frees up when the
// receiver stalls.
// Reset empties the table at once (the entry count goes to zero); the
// memory is not cleared.
module sorted_key_index_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  skit_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output skit_pkg::rsp_type rsp_data
);

   localparam int KW = skit_pkg::KEY_W;
   localparam int CW = skit_pkg::CNT_W;
   localparam int AW = skit_pkg::ADDR_W;

   skit_pkg::state_type           state_ff, state_in;
   logic [1:0]                    op_ff, op_in;
   logic [KW-1:0]                 key_ff, key_in;
   logic [skit_pkg::OFF_W-1:0]    off_ff, off_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 lo_ff, lo_in;
   logic [CW-1:0]                 hi_ff, hi_in;
   logic [CW-1:0]                 mid_ff, mid_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic                          hit_ff, hit_in;
   logic [skit_pkg::OFF_W-1:0]    hitoff_ff, hitoff_in;
   logic [1:0]                    res_status_ff, res_status_in;
   logic [skit_pkg::OFF_W-1:0]    res_found_ff, res_found_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   skit_pkg::rsp_type             rsp_ff, rsp_in;

   skit_pkg::mem_cmd_type         cmd;
   skit_pkg::entry_type           rd_data;
   logic [CW:0]                   mid_sum;
   logic                          key_lt, key_eq;
   logic [CW-1:0]                 idx_next;

   function automatic logic [KW-1:0] normalize(input logic [KW-1:0] raw);
      logic [KW-1:0] res;
      logic          ended;
      res   = '0;
      ended = 1'b0;
      for (int b = skit_pkg::KEY_BYTES - 1; b >= 0; b--) begin
         if (raw[8*b +: 8] == 8'd0) begin
            ended = 1'b1;
         end
         if (!ended) begin
            res[8*b +: 8] = raw[8*b +: 8];
         end
      end
      return res;
   endfunction

   skit_store u_store (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   // single key comparator shared by every probe
   assign key_lt  = rd_data.key < key_ff;
   assign key_eq  = rd_data.key == key_ff;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign idx_next = idx_ff + CW'(1);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      off_in        = off_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      hitoff_in     = hitoff_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      cmd           = '0;
      req_ready     = 1'b0;

      case (state_ff)
         skit_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_data.opcode;
               key_in   = normalize(req_data.key);
               off_in   = req_data.offset;
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = skit_pkg::S_SEARCH;
            end
         end
         skit_pkg::S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in    = mid_sum[CW:1];
               cmd.raddr = mid_sum[AW:1];
               state_in  = skit_pkg::S_CMP;
            end else if (lo_ff < count_ff) begin
               cmd.raddr = lo_ff[AW-1:0];
               state_in  = skit_pkg::S_HITCMP;
            end else begin
               hit_in   = 1'b0;
               state_in = skit_pkg::S_DECIDE;
            end
         end
         skit_pkg::S_CMP: begin
            if (key_lt) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = skit_pkg::S_SEARCH;
         end
         skit_pkg::S_HITCMP: begin
            hit_in    = key_eq;
            hitoff_in = rd_data.offset;
            state_in  = skit_pkg::S_DECIDE;
         end
         skit_pkg::S_DECIDE: begin
            res_status_in = skit_pkg::ST_OK;
            res_found_in  = '0;
            state_in      = skit_pkg::S_DONE;
            case (op_ff)
               skit_pkg::OP_INSERT: begin
                  if (count_ff >= CW'(skit_pkg::TABLE_DEPTH)) begin
                     res_status_in = skit_pkg::ST_FULL;
                  end else if (hit_ff) begin
                     res_status_in = skit_pkg::ST_DUPLICATE;
                  end else begin
                     idx_in   = count_ff;
                     state_in = skit_pkg::S_INS_RD;
                  end
               end
               skit_pkg::OP_LOOKUP, skit_pkg::OP_DELETE: begin
                  if (!hit_ff) begin
                     res_status_in = skit_pkg::ST_NOT_FOUND;
                  end else begin
                     res_found_in = hitoff_ff;
                     if (op_ff == skit_pkg::OP_DELETE) begin
                        idx_in   = lo_ff;
                        state_in = skit_pkg::S_DEL_RD;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         skit_pkg::S_INS_RD: begin
            if (idx_ff == lo_ff) begin
               cmd.we          = 1'b1;
               cmd.waddr       = idx_ff[AW-1:0];
               cmd.wdata.key   = key_ff;
               cmd.wdata.offset = off_ff;
               count_in        = count_ff + CW'(1);
               state_in        = skit_pkg::S_DONE;
            end else begin
               cmd.raddr = AW'(idx_ff - CW'(1));
               state_in  = skit_pkg::S_INS_WR;
            end
         end
         skit_pkg::S_INS_WR: begin
            cmd.we    = 1'b1;
            cmd.waddr = idx_ff[AW-1:0];
            cmd.wdata = rd_data;
            idx_in    = idx_ff - CW'(1);
            state_in  = skit_pkg::S_INS_RD;
         end
         skit_pkg::S_DEL_RD: begin
            if (idx_next >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = skit_pkg::S_DONE;
            end else begin
               cmd.raddr = idx_next[AW-1:0];
               state_in  = skit_pkg::S_DEL_WR;
            end
         end
         skit_pkg::S_DEL_WR: begin
            cmd.we    = 1'b1;
            cmd.waddr = idx_ff[AW-1:0];
            cmd.wdata = rd_data;
            idx_in    = idx_next;
            state_in  = skit_pkg::S_DEL_RD;
         end
         skit_pkg::S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = res_status_ff;
               rsp_in.found_offset = res_found_ff;
               rsp_in.entry_count  = count_ff;
               state_in            = skit_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = skit_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skit_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      off_ff        <= off_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      hitoff_ff     <= hitoff_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/skit_checker.sv =====
// port-level checks for sorted_key_index_table, attached by bind
// depends on skit_pkg
module skit_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input skit_pkg::rsp_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == skit_pkg::ST_FULL
      |-> rsp_data.entry_count == skit_pkg::CNT_W'(skit_pkg::TABLE_DEPTH))
      else $error("full status with table not full");

   a_fail_no_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != skit_pkg::ST_OK |-> rsp_data.found_offset == '0)
      else $error("offset reported on a failed request");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= skit_pkg::CNT_W'(skit_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // a request is accepted only with no earlier one in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind sorted_key_index_table skit_checker u_skit_checker (.*);
